[rtl/brm_pkg.sv]
`timescale 1ns / 1ps

package brm_pkg;

  // default sizing, handed to the top level parameters
  localparam int NUM_REGS_DEFAULT   = 6;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // field widths
  localparam int OP_W      = 4;
  localparam int OPERAND_W = 31;
  localparam int DEST_W    = 3;
  localparam int BIND_W    = 3;
  localparam int PLEN_W    = 13;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IP_BINDING     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 1'd1;

  // opcodes
  typedef enum logic [OP_W-1:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } op_t;

  // status of one executed instruction
  typedef struct packed {
    logic halted;
    logic bad_index;
  } exec_flags_t;

endpackage

[rtl/bound_ip_register_machine_step.sv]
`timescale 1ns / 1ps

// channel | signals                                                   | direction
// --------+-----------------------------------------------------------+----------
// in      | in_valid in_ready operation operand_a operand_b dest_reg  | to block
//         | clear                                                     |
// out     | out_valid out_ready next_ip first_register halted         | from block
//         | bad_index                                                 |
// cfg     | cfg_we cfg_index cfg_data                                 | to block
//
// One instruction per cycle when not stalled: an accepted transaction waits in the
// input register, executes through the register file and alu, and lands in the result
// register, which raises out_valid; a new transaction is taken every cycle unless stalled.
// Synchronous reset zeroes the register file, pointer, configuration and both valid flags.
// A stalled result holds the input register; in_ready drops only when both stages are full
// and out_ready is low.

module bound_ip_register_machine_step import brm_pkg::*; #(
  parameter int NUM_REGS   = NUM_REGS_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       operation,
  input  logic [OPERAND_W-1:0]  operand_a,
  input  logic [OPERAND_W-1:0]  operand_b,
  input  logic [DEST_W-1:0]     dest_reg,
  input  logic                  clear,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [OUT_W-1:0] next_ip,
  output logic signed [OUT_W-1:0] first_register,
  output logic                  halted,
  output logic                  bad_index
);

  // configuration
  logic [BIND_W-1:0] ip_binding;
  logic [PLEN_W-1:0] program_length;

  // architectural state
  logic [DATA_WIDTH-1:0] regs [NUM_REGS];
  logic [DATA_WIDTH-1:0] ip;

  // input register
  logic                 s1_valid;
  op_t                  s1_op;
  logic [OPERAND_W-1:0] s1_a;
  logic [OPERAND_W-1:0] s1_b;
  logic [DEST_W-1:0]    s1_dst;
  logic                 s1_clear;

  logic                  advance;
  logic                  fire;
  logic [DATA_WIDTH-1:0] regs_next [NUM_REGS];
  logic [DATA_WIDTH-1:0] ip_next;
  exec_flags_t           flags;

  // pipeline control
  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ip_binding     <= '0;
      program_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IP_BINDING:     ip_binding     <= cfg_data[BIND_W-1:0];
        CFG_PROGRAM_LENGTH: program_length <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op    <= op_t'(operation);
      s1_a     <= operand_a;
      s1_b     <= operand_b;
      s1_dst   <= dest_reg;
      s1_clear <= clear;
    end
  end

  brm_exec #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_exec (
    .regs           (regs),
    .ip             (ip),
    .ip_binding     (ip_binding),
    .program_length (program_length),
    .op             (s1_op),
    .operand_a      (s1_a),
    .operand_b      (s1_b),
    .dest_reg       (s1_dst),
    .clear          (s1_clear),
    .regs_next      (regs_next),
    .ip_next        (ip_next),
    .flags          (flags)
  );

  // register file and pointer commit
  always_ff @(posedge clk) begin
    if (rst) begin
      ip <= '0;
      for (int k = 0; k < NUM_REGS; k++) begin
        regs[k] <= '0;
      end
    end else if (fire) begin
      ip <= ip_next;
      for (int k = 0; k < NUM_REGS; k++) begin
        regs[k] <= regs_next[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      next_ip        <= OUT_W'($signed(ip_next));
      first_register <= OUT_W'($signed(regs_next[0]));
      halted         <= flags.halted;
      bad_index      <= flags.bad_index;
    end
  end

  // checks
  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("executed transaction did not reach the result register");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    fire && s1_clear |=> ip == '0 && first_register == '0 && !bad_index)
    else $error("clear left state or flags set");

  a_clear_halt: assert property (@(posedge clk) disable iff (rst)
    fire && s1_clear |=> halted == (program_length == '0))
    else $error("halt flag wrong after clear");

  a_seti_ok: assert property (@(posedge clk) disable iff (rst)
    fire && !s1_clear && s1_op == OP_SETI && int'(s1_dst) < NUM_REGS |=> !bad_index)
    else $error("immediate set with valid destination flagged");

  a_ip_stable: assert property (@(posedge clk) disable iff (rst)
    !fire && !$past(rst) |=> $stable(ip))
    else $error("pointer moved without an executed transaction");

endmodule

[rtl/brm_exec.sv]
`timescale 1ns / 1ps

module brm_exec import brm_pkg::*; #(
  parameter int NUM_REGS   = NUM_REGS_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic [DATA_WIDTH-1:0] regs [NUM_REGS],
  input  logic [DATA_WIDTH-1:0] ip,
  input  logic [BIND_W-1:0]     ip_binding,
  input  logic [PLEN_W-1:0]     program_length,
  input  op_t                   op,
  input  logic [OPERAND_W-1:0]  operand_a,
  input  logic [OPERAND_W-1:0]  operand_b,
  input  logic [DEST_W-1:0]     dest_reg,
  input  logic                  clear,
  output logic [DATA_WIDTH-1:0] regs_next [NUM_REGS],
  output logic [DATA_WIDTH-1:0] ip_next,
  output exec_flags_t           flags
);

  localparam int IW = $clog2(NUM_REGS);
  localparam int CW = (DATA_WIDTH > PLEN_W) ? DATA_WIDTH : PLEN_W;

  logic                  bound;
  logic [IW-1:0]         bind_idx;
  logic [DATA_WIDTH-1:0] eff [NUM_REGS];
  logic                  a_is_imm;
  logic                  b_unused;
  logic                  b_is_reg;
  logic                  a_ok;
  logic                  b_ok;
  logic                  dst_ok;
  logic [IW-1:0]         a_idx;
  logic [IW-1:0]         b_idx;
  logic [IW-1:0]         dst_idx;
  logic [DATA_WIDTH-1:0] a_reg;
  logic [DATA_WIDTH-1:0] b_reg;
  logic [DATA_WIDTH-1:0] a_val;
  logic [DATA_WIDTH-1:0] b_val;
  logic [DATA_WIDTH-1:0] result;
  logic                  bad;
  logic                  wr;
  logic [DATA_WIDTH-1:0] ipw;

  // bound register sees the pointer before the instruction runs
  always_comb begin
    bound    = int'(ip_binding) < NUM_REGS;
    bind_idx = IW'(ip_binding);
    for (int k = 0; k < NUM_REGS; k++) begin
      eff[k] = (bound && bind_idx == IW'(k)) ? ip : regs[k];
    end
  end

  // operand decode and register reads
  always_comb begin
    a_is_imm = op inside {OP_SETI, OP_GTIR, OP_EQIR};
    b_unused = op inside {OP_SETR, OP_SETI};
    b_is_reg = op inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
                          OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR};
    a_ok     = operand_a < OPERAND_W'(NUM_REGS);
    b_ok     = operand_b < OPERAND_W'(NUM_REGS);
    dst_ok   = int'(dest_reg) < NUM_REGS;
    a_idx    = IW'(operand_a);
    b_idx    = IW'(operand_b);
    dst_idx  = IW'(dest_reg);
    a_reg    = '0;
    b_reg    = '0;
    for (int k = 0; k < NUM_REGS; k++) begin
      if (a_ok && a_idx == IW'(k)) a_reg = eff[k];
      if (b_ok && b_idx == IW'(k)) b_reg = eff[k];
    end
    a_val = a_is_imm ? DATA_WIDTH'(operand_a) : a_reg;
    if (b_unused) begin
      b_val = '0;
    end else if (b_is_reg) begin
      b_val = b_reg;
    end else begin
      b_val = DATA_WIDTH'(operand_b);
    end
    bad = (!a_is_imm && !a_ok) || (b_is_reg && !b_ok) || !dst_ok;
  end

  // alu
  always_comb begin
    case (op)
      OP_ADDR, OP_ADDI: result = a_val + b_val;
      OP_MULR, OP_MULI: result = a_val * b_val;
      OP_BANR, OP_BANI: result = a_val & b_val;
      OP_BORR, OP_BORI: result = a_val | b_val;
      OP_SETR, OP_SETI: result = a_val;
      OP_GTIR, OP_GTRI, OP_GTRR:
        result = DATA_WIDTH'($signed(a_val) > $signed(b_val));
      default: result = DATA_WIDTH'(a_val == b_val);
    endcase
  end

  // write back, pointer advance and status
  always_comb begin
    wr  = !bad;
    ipw = (bound && wr && dst_idx == bind_idx) ? result : ip;
    for (int k = 0; k < NUM_REGS; k++) begin
      if (clear) begin
        regs_next[k] = '0;
      end else if (wr && dst_idx == IW'(k)) begin
        regs_next[k] = result;
      end else begin
        regs_next[k] = eff[k];
      end
    end
    ip_next          = clear ? '0 : ipw + DATA_WIDTH'(1);
    flags.halted     = ip_next[DATA_WIDTH-1] || (CW'(ip_next) >= CW'(program_length));
    flags.bad_index  = !clear && bad;
  end

endmodule
